FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_PROP(lbl, !(cond), msg)

`endif

FILE: rtl/core/ppoc_pkg.sv
// ----------------------------------------------------------------------------
// Printer output controller package
// Types, codes and constants shared by the controller and its checker.
// ----------------------------------------------------------------------------
package ppoc_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 10;
    localparam int CFG_W       = 10;

    localparam logic [9:0] HIGH_WATER_RST = 10'd300;
    localparam logic [9:0] LOW_WATER_RST  = 10'd50;
    localparam logic [7:0] TIMEOUT_RST    = 8'd20;

    localparam logic [7:0] ST_MASK   = 8'hF8;
    localparam logic [7:0] ST_INVERT = 8'hC8;
    localparam int ST_BUSY_BIT   = 7;
    localparam int ST_NOPAP_BIT  = 5;
    localparam int ST_SELECT_BIT = 4;
    localparam int ST_ERROR_BIT  = 3;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_STATUS  = 2'd1,
        OP_TICK    = 2'd2,
        OP_ABORT   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_NOPAPER = 2'd1,
        ERR_OFFLINE = 2'd2,
        ERR_UNKNOWN = 2'd3
    } err_kind_t;

    typedef enum logic [1:0] {
        CFG_HIGH_WATER = 2'd0,
        CFG_LOW_WATER  = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [7:0] raw_status;
    } in_item_t;

    typedef struct packed {
        logic             strobe_valid;
        logic [7:0]       data_out;
        logic             accepted;
        logic             intr_enable;
        logic             active;
        logic [1:0]       error_kind;
        logic [CNT_W-1:0] queue_level;
        logic             below_low_water;
    } out_item_t;

endpackage

FILE: rtl/core/parallel_printer_output_controller.sv
// ----------------------------------------------------------------------------
// Parallel printer output controller
// Queues bytes for a parallel printer and strobes one out per ready event.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Beat
// in       input      in_valid/in_stall   one event: opcode, data, raw status
// out      output     out_valid/out_stall one result per event
// cfg      input      cfg_we              one register write
//
// One event is taken every cycle unless the result side stalls; its result passes
// through the input register, then the result register.
// The byte queue is a 512-entry memory with one write and one read port; the
// byte at the head is read ahead into a register, so a strobe need not wait on a read.
// Reset clears pointers, count and flags at once; the queue memory is not
// cleared and needs no sweep.
// A stall on the result side reaches the input stall in the same cycle.
// ----------------------------------------------------------------------------
module parallel_printer_output_controller
    import ppoc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [7:0]       queue_mem [QUEUE_DEPTH];
    logic [7:0]       head_data_reg;

    in_item_t         in_reg;
    logic             in_vld_reg;
    logic             in_vld_next;
    out_item_t        out_reg;
    out_item_t        res_next;
    logic             out_vld_reg;
    logic             out_vld_next;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             busy_reg;
    logic             busy_next;
    logic             fault_reg;
    logic             fault_next;
    logic             irq_reg;
    logic             irq_next;
    logic [7:0]       stall_ticks_reg;
    logic [7:0]       stall_ticks_next;

    logic [9:0]       high_water_reg;
    logic [9:0]       low_water_reg;
    logic [7:0]       timeout_reg;

    logic             out_load;
    logic             fire;
    logic [7:0]       status;
    logic             accept_byte;
    logic             run_step;
    logic             printer_ready;
    logic             wr_en;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       strobe_byte;

    assign out_load  = !out_vld_reg || !out_stall;
    assign fire      = in_vld_reg && out_load;
    assign in_stall  = in_vld_reg && !out_load;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    assign status        = (in_reg.raw_status & ST_MASK) ^ ST_INVERT;
    assign printer_ready = !status[ST_BUSY_BIT] && !status[ST_ERROR_BIT]
                           && !status[ST_NOPAP_BIT];
    assign accept_byte   = (count_reg < high_water_reg)
                           && (count_reg < CNT_W'(QUEUE_DEPTH));
    assign wr_en         = fire && (opcode_t'(in_reg.opcode) == OP_ENQUEUE) && accept_byte;
    assign rd_addr       = fire ? head_next : head_reg;

    // An empty queue can only be strobed from on the beat that fills it.
    assign strobe_byte   = (count_reg == '0) ? in_reg.data_byte : head_data_reg;

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        busy_next        = busy_reg;
        fault_next       = fault_reg;
        irq_next         = irq_reg;
        stall_ticks_next = stall_ticks_reg;
        run_step         = 1'b0;
        res_next         = '0;

        unique case (opcode_t'(in_reg.opcode))
            OP_ENQUEUE:
            begin
                if (accept_byte)
                begin
                    tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    res_next.accepted = 1'b1;
                end
                if (!busy_reg)
                begin
                    busy_next = 1'b1;
                    run_step  = 1'b1;
                end
            end
            OP_STATUS:
            begin
                run_step = busy_reg && !status[ST_BUSY_BIT];
            end
            OP_TICK:
            begin
                if (irq_reg)
                begin
                    if (stall_ticks_reg >= timeout_reg)
                    begin
                        fault_next = 1'b1;
                        run_step   = 1'b1;
                    end
                    else if (stall_ticks_reg != 8'hFF)
                    begin
                        stall_ticks_next = stall_ticks_reg + 1'b1;
                    end
                end
            end
            OP_ABORT:
            begin
                if (fault_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                    busy_next  = 1'b0;
                    fault_next = 1'b0;
                    irq_next   = 1'b0;
                end
            end
            default:
            begin
                run_step = 1'b0;
            end
        endcase

        if (run_step)
        begin
            if (printer_ready)
            begin
                stall_ticks_next = '0;
                fault_next       = 1'b0;
                if (count_next != '0)
                begin
                    res_next.strobe_valid = 1'b1;
                    res_next.data_out     = strobe_byte;
                    head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                 : head_reg + 1'b1;
                    count_next = count_next - 1'b1;
                end
            end
            irq_next = (count_next != '0);
            if (status[ST_ERROR_BIT] || status[ST_NOPAP_BIT] || fault_next)
            begin
                priority if (status[ST_NOPAP_BIT])
                begin
                    res_next.error_kind = ERR_NOPAPER;
                end
                else if (!status[ST_SELECT_BIT])
                begin
                    res_next.error_kind = ERR_OFFLINE;
                end
                else
                begin
                    res_next.error_kind = ERR_UNKNOWN;
                end
                stall_ticks_next = '0;
            end
            if (count_next == '0)
            begin
                busy_next = 1'b0;
            end
        end

        res_next.intr_enable     = irq_next;
        res_next.active          = busy_next;
        res_next.queue_level     = count_next;
        res_next.below_low_water = (count_next <= low_water_reg);

        in_vld_next = (in_valid && !in_stall) ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
        out_vld_next = out_load ? fire : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            busy_reg        <= 1'b0;
            fault_reg       <= 1'b0;
            irq_reg         <= 1'b0;
            stall_ticks_reg <= '0;
            high_water_reg  <= HIGH_WATER_RST;
            low_water_reg   <= LOW_WATER_RST;
            timeout_reg     <= TIMEOUT_RST;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                count_reg       <= count_next;
                busy_reg        <= busy_next;
                fault_reg       <= fault_next;
                irq_reg         <= irq_next;
                stall_ticks_reg <= stall_ticks_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_HIGH_WATER: high_water_reg <= cfg_wdata;
                    CFG_LOW_WATER:  low_water_reg  <= cfg_wdata;
                    CFG_TIMEOUT:    timeout_reg    <= cfg_wdata[7:0];
                    default:        timeout_reg    <= timeout_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_reg <= in_item;
        end
        if (fire && out_load)
        begin
            out_reg <= res_next;
        end
    end

    // The head byte is read ahead; a write to the entry being read is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[tail_reg] <= in_reg.data_byte;
        end
        if (wr_en && (tail_reg == rd_addr))
        begin
            head_data_reg <= in_reg.data_byte;
        end
        else
        begin
            head_data_reg <= queue_mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/ppoc_checker.sv
// ----------------------------------------------------------------------------
// Printer output controller checker
// Port-level checks on the result channel, bound to the controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppoc_checker
    import ppoc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    `ASSERT_PROP(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result beat changed")
    `ASSERT_NEVER(a_data_no_strobe, out_valid && !out_item.strobe_valid && (out_item.data_out != 8'd0), "data driven without a strobe")
    `ASSERT_NEVER(a_level_range, out_valid && (out_item.queue_level > CNT_W'(QUEUE_DEPTH)), "queue level beyond depth")
    `ASSERT_NEVER(a_idle_empty, out_valid && !out_item.active && (out_item.queue_level != '0), "idle with bytes queued")
    `ASSERT_PROP(a_irq_level, out_valid && out_item.strobe_valid |-> out_item.intr_enable == (out_item.queue_level != '0), "interrupt enable does not follow the queue level")

endmodule

bind parallel_printer_output_controller ppoc_checker u_ppoc_checker (.*);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Printer output controller testbench
// Drives enqueue, status, tick and abort beats into the controller and checks
// every result beat against scripted values or an in-bench model of the queue,
// the watchdog and error diagnosis. A short scripted sequence comes first, then
// random print jobs, stuck jobs and noise under varied settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import ppoc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {ROW_EVENT, ROW_CHECKED, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t        kind;
        in_item_t         stim;
        cfg_index_t       reg_idx;
        logic [CFG_W-1:0] reg_val;
        out_item_t        result;
    } plan_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_addr  = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic [7:0]       pr_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] pr_head     = '0;
    logic [PTR_W-1:0] pr_tail     = '0;
    logic [CNT_W-1:0] pr_count    = '0;
    logic             pr_printing = 1'b0;
    logic             pr_fault    = 1'b0;
    logic             pr_irq      = 1'b0;
    logic [7:0]       pr_stall    = '0;
    logic [CFG_W-1:0] lim_high    = HIGH_WATER_RST;
    logic [CFG_W-1:0] lim_low     = LOW_WATER_RST;
    logic [7:0]       lim_timeout = TIMEOUT_RST;

    out_item_t pending_results [$];
    plan_row_t script [$];
    int        fail_count     = 0;
    int        sent_events    = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        hold_req       = 0;
    int        hold_left      = 0;

    parallel_printer_output_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void run_output_step(input logic [7:0] s, inout out_item_t r);
        pr_irq = 1'b0;
        if (!s[ST_BUSY_BIT] && !s[ST_ERROR_BIT] && !s[ST_NOPAP_BIT])
        begin
            pr_stall = '0;
            pr_fault = 1'b0;
            if (pr_count != 0)
            begin
                r.strobe_valid = 1'b1;
                r.data_out     = pr_mem[pr_head];
                pr_head        = pr_head + 1'b1;
                pr_count       = pr_count - 1'b1;
            end
        end
        if (pr_count != 0)
            pr_irq = 1'b1;
        if (s[ST_ERROR_BIT] || s[ST_NOPAP_BIT] || pr_fault)
        begin
            if (s[ST_NOPAP_BIT])
                r.error_kind = ERR_NOPAPER;
            else if (!s[ST_SELECT_BIT])
                r.error_kind = ERR_OFFLINE;
            else
                r.error_kind = ERR_UNKNOWN;
            pr_stall = '0;
        end
        if (pr_count == 0)
            pr_printing = 1'b0;
    endfunction

    function automatic out_item_t predict_printer(input in_item_t beat);
        out_item_t  r;
        logic [7:0] s;
        r = '0;
        s = (beat.raw_status & ST_MASK) ^ ST_INVERT;
        case (opcode_t'(beat.opcode))
            OP_ENQUEUE:
            begin
                if (pr_count < lim_high && pr_count < QUEUE_DEPTH)
                begin
                    pr_mem[pr_tail] = beat.data_byte;
                    pr_tail         = pr_tail + 1'b1;
                    pr_count        = pr_count + 1'b1;
                    r.accepted      = 1'b1;
                end
                if (!pr_printing)
                begin
                    pr_printing = 1'b1;
                    run_output_step(s, r);
                end
            end
            OP_STATUS:
            begin
                if (pr_printing && !s[ST_BUSY_BIT])
                    run_output_step(s, r);
            end
            OP_TICK:
            begin
                if (pr_irq)
                begin
                    if (pr_stall >= lim_timeout)
                    begin
                        pr_fault = 1'b1;
                        run_output_step(s, r);
                    end
                    else if (pr_stall != 8'hFF)
                        pr_stall = pr_stall + 1'b1;
                end
            end
            default:
            begin
                if (pr_fault)
                begin
                    pr_head     = '0;
                    pr_tail     = '0;
                    pr_count    = '0;
                    pr_printing = 1'b0;
                    pr_fault    = 1'b0;
                    pr_irq      = 1'b0;
                end
            end
        endcase
        r.intr_enable     = pr_irq;
        r.active          = pr_printing;
        r.queue_level     = pr_count;
        r.below_low_water = (pr_count <= lim_low);
        return r;
    endfunction

    // The raw busy and error lines are active low.
    function automatic logic [7:0] pick_status(input int ready_pct);
        logic [7:0] raw;
        int         roll;
        raw  = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < ready_pct)
        begin
            raw[ST_BUSY_BIT]  = 1'b1;
            raw[ST_ERROR_BIT] = 1'b1;
            raw[ST_NOPAP_BIT] = 1'b0;
        end
        else if (roll < ready_pct + (100 - ready_pct) / 2)
            raw[ST_BUSY_BIT] = 1'b0;
        else
        begin
            raw[ST_BUSY_BIT] = 1'b1;
            if (raw[0])
                raw[ST_ERROR_BIT] = 1'b0;
            else
                raw[ST_NOPAP_BIT] = 1'b1;
        end
        return raw;
    endfunction

    function automatic out_item_t res(input bit strobe, input logic [7:0] dout, input bit acc,
                                      input bit irq, input bit act, input err_kind_t kind,
                                      input logic [CNT_W-1:0] level, input bit below);
        out_item_t r;
        r.strobe_valid    = strobe;
        r.data_out        = dout;
        r.accepted        = acc;
        r.intr_enable     = irq;
        r.active          = act;
        r.error_kind      = kind;
        r.queue_level     = level;
        r.below_low_water = below;
        return r;
    endfunction

    function automatic plan_row_t ck(input opcode_t op, input logic [7:0] data,
                                     input logic [7:0] raw, input out_item_t want);
        plan_row_t row;
        row.kind            = ROW_CHECKED;
        row.stim.opcode     = op;
        row.stim.data_byte  = data;
        row.stim.raw_status = raw;
        row.reg_idx         = CFG_UNUSED;
        row.reg_val         = '0;
        row.result          = want;
        return row;
    endfunction

    function automatic plan_row_t ev(input opcode_t op, input logic [7:0] data,
                                     input logic [7:0] raw);
        plan_row_t row;
        row      = ck(op, data, raw, '0);
        row.kind = ROW_EVENT;
        return row;
    endfunction

    function automatic plan_row_t wr(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        plan_row_t row;
        row         = ck(OP_ENQUEUE, '0, '0, '0);
        row.kind    = ROW_CONFIG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic compare_field(input string name, input logic [9:0] want,
                                 input logic [9:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic send_event(input opcode_t op, input logic [7:0] data, input logic [7:0] raw,
                              input bit typed = 1'b0, input out_item_t want = '0);
        in_item_t  beat;
        out_item_t predicted;
        beat.opcode     = op;
        beat.data_byte  = data;
        beat.raw_status = raw;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_printer(beat);
        pending_results.push_back(typed ? want : predicted);
        sent_events++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HIGH_WATER: lim_high = val;
            CFG_LOW_WATER:  lim_low = val;
            CFG_TIMEOUT:    lim_timeout = val[7:0];
            default:        ;
        endcase
    endtask

    task automatic set_limits(input int high, input int low, input int ticks);
        write_register(CFG_HIGH_WATER, CFG_W'(high));
        write_register(CFG_LOW_WATER, CFG_W'(low));
        write_register(CFG_TIMEOUT, CFG_W'(ticks));
    endtask

    task automatic random_jobs(input int budget);
        int stop_at;
        int pick;
        int len;
        int ticks;
        stop_at = sent_events + budget;
        while (sent_events < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    send_event(OP_ENQUEUE, 8'($urandom), pick_status(40));
                    if ($urandom_range(0, 1) == 1)
                        send_event(OP_STATUS, 8'($urandom), pick_status(75));
                end
                repeat ($urandom_range(0, len))
                    send_event(OP_STATUS, 8'($urandom), pick_status(80));
            end
            else if (pick < 7)
            begin
                repeat ($urandom_range(1, 4))
                    send_event(OP_ENQUEUE, 8'($urandom), pick_status(0));
                if (lim_timeout < 16)
                    ticks = lim_timeout + $urandom_range(1, 3);
                else
                    ticks = $urandom_range(1, 12);
                repeat (ticks)
                    send_event(OP_TICK, 8'($urandom), pick_status(10));
                if ($urandom_range(0, 3) != 0)
                    send_event(OP_ABORT, 8'($urandom), 8'($urandom));
                else
                    send_event(OP_STATUS, 8'($urandom), pick_status(100));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_event(opcode_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %p", $time, out_item);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("strobe_valid", want.strobe_valid, out_item.strobe_valid);
                compare_field("data_out", want.data_out, out_item.data_out);
                compare_field("accepted", want.accepted, out_item.accepted);
                compare_field("intr_enable", want.intr_enable, out_item.intr_enable);
                compare_field("active", want.active, out_item.active);
                compare_field("error_kind", want.error_kind, out_item.error_kind);
                compare_field("queue_level", want.queue_level, out_item.queue_level);
                compare_field("below_low_water", want.below_low_water,
                              out_item.below_low_water);
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_req - 1;
            hold_req  = 0;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        script.push_back(ck(OP_TICK, 8'h00, 8'h00, res(0, 0, 0, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(ck(OP_ABORT, 8'hFF, 8'hFF, res(0, 0, 0, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'hFF, res(0, 0, 0, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(ck(OP_ENQUEUE, 8'hFF, 8'h88, res(1, 8'hFF, 1, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(ck(OP_ENQUEUE, 8'h00, 8'h00, res(0, 0, 1, 1, 1, ERR_OFFLINE, 1, 1)));
        script.push_back(ck(OP_ENQUEUE, 8'hA5, 8'h00, res(0, 0, 1, 1, 1, ERR_NONE, 2, 1)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'h7F, res(0, 0, 0, 1, 1, ERR_NONE, 2, 1)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'hB8, res(0, 0, 0, 1, 1, ERR_NOPAPER, 2, 1)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'h90, res(0, 0, 0, 1, 1, ERR_UNKNOWN, 2, 1)));
        script.push_back(ev(OP_ENQUEUE, 8'hC3, 8'h48));
        script.push_back(wr(CFG_TIMEOUT, 10'd1));
        script.push_back(ck(OP_TICK, 8'h00, 8'h00, res(0, 0, 0, 1, 1, ERR_NONE, 3, 1)));
        script.push_back(ck(OP_TICK, 8'h00, 8'h00, res(0, 0, 0, 1, 1, ERR_OFFLINE, 3, 1)));
        script.push_back(ck(OP_ABORT, 8'h00, 8'h00, res(0, 0, 0, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(wr(CFG_HIGH_WATER, 10'd0));
        script.push_back(ck(OP_ENQUEUE, 8'h3C, 8'h00, res(0, 0, 0, 0, 0, ERR_OFFLINE, 0, 1)));
        script.push_back(wr(CFG_HIGH_WATER, 10'd1));
        script.push_back(wr(CFG_TIMEOUT, 10'd0));
        script.push_back(ck(OP_ENQUEUE, 8'h5A, 8'h00, res(0, 0, 1, 1, 1, ERR_OFFLINE, 1, 1)));
        script.push_back(ck(OP_ENQUEUE, 8'h11, 8'hFF, res(0, 0, 0, 1, 1, ERR_NONE, 1, 1)));
        script.push_back(ck(OP_TICK, 8'h00, 8'hFF, res(0, 0, 0, 1, 1, ERR_NOPAPER, 1, 1)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'h88, res(1, 8'h5A, 0, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(wr(CFG_HIGH_WATER, 10'd512));
        script.push_back(wr(CFG_LOW_WATER, 10'd0));
        script.push_back(wr(CFG_TIMEOUT, 10'd255));
        script.push_back(ck(OP_ENQUEUE, 8'h80, 8'h08, res(0, 0, 1, 1, 1, ERR_NONE, 1, 0)));
        script.push_back(ck(OP_ENQUEUE, 8'h01, 8'h08, res(0, 0, 1, 1, 1, ERR_NONE, 2, 0)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'h88, res(1, 8'h80, 0, 1, 1, ERR_NONE, 1, 0)));
        script.push_back(ck(OP_STATUS, 8'h00, 8'h88, res(1, 8'h01, 0, 0, 0, ERR_NONE, 0, 1)));
        script.push_back(ev(OP_TICK, 8'h5A, 8'h00));
        script.push_back(wr(CFG_UNUSED, 10'h3FF));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CONFIG:
                    write_register(script[i].reg_idx, script[i].reg_val);
                ROW_CHECKED:
                    send_event(opcode_t'(script[i].stim.opcode), script[i].stim.data_byte,
                               script[i].stim.raw_status, 1'b1, script[i].result);
                default:
                    send_event(opcode_t'(script[i].stim.opcode), script[i].stim.data_byte,
                               script[i].stim.raw_status);
            endcase
        end

        set_limits(300, 50, 20);
        random_jobs(70);

        send_idle_pct = 72;
        set_limits(1, 0, 1);
        random_jobs(70);

        send_idle_pct  = 0;
        recv_stall_pct = 72;
        set_limits(512, 512, 8);
        random_jobs(70);

        send_idle_pct  = 17;
        recv_stall_pct = 17;
        set_limits($urandom_range(2, 64), 0, $urandom_range(1, 6));
        write_register(CFG_LOW_WATER, CFG_W'($urandom_range(0, lim_high)));
        random_jobs(35);
        drain_results();
        random_jobs(35);

        // Fill the queue to its depth behind a long result hold-off, then let
        // the watchdog fault at the longest timeout and flush with an abort.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_limits(512, 255, 255);
        hold_req = 400;
        repeat (530)
            send_event(OP_ENQUEUE, 8'($urandom), pick_status(0));
        repeat (20)
            send_event(OP_STATUS, 8'($urandom), pick_status(100));
        repeat (260)
            send_event(OP_TICK, 8'($urandom), pick_status(0));
        send_event(OP_ABORT, 8'($urandom), 8'($urandom));

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
